// File: hw/rtl/rcra_pkg.sv
// package for the range raise / range average block
// holds request, result and action types, the sequencer state type, the divider control type and widths
// no dependencies
`timescale 1ns / 1ps
package rcra_pkg;
    localparam int IDX_W = 11;
    localparam int VAL_W = 31;
    localparam int NUM_W = 41;

    typedef enum logic
    {
        ACT_RAISE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed
    {
        logic             action;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
        logic [VAL_W-1:0] floor_value;
    } req_t;

    typedef struct packed
    {
        logic [NUM_W-1:0] numerator;
        logic [IDX_W-1:0] denominator;
        logic             range_error;
    } res_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_APPLY,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_OUT
    } state_t;

    // start and busy between the sequencer and the divider
    typedef struct packed
    {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

// File: hw/rtl/rcra_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on rcra_pkg
`timescale 1ns / 1ps
module rcra_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rcra_pkg::NUM_W-1:0] dividend,
    input  logic [rcra_pkg::NUM_W-1:0] divisor,
    output rcra_pkg::div_ctl_t       ctl,
    output logic [rcra_pkg::NUM_W-1:0] quotient,
    output logic [rcra_pkg::NUM_W-1:0] remainder
);
    import rcra_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [NUM_W:0]   trial;

    // load on start, otherwise one shift and subtract step while busy
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = NUM_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NUM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// File: hw/rtl/range_chmax_range_average.sv
// top level: element memory, walk sequencer, gcd reduction
// depends on rcra_pkg and rcra_div
//
// channel | dir | handshake          | payload
// req     | in  | req_valid/ready    | rcra_pkg::req_t
// res     | out | res_valid/ready    | rcra_pkg::res_t
// cfg     | in  | cfg_valid/ready    | array_length, 11 bits
//
// elements are walked one at a time through the memory port, in the states
// read, wait and apply for each element in the range; a query then runs a
// gcd by repeated division and two more divisions.
// after reset a clearing pass zeroes every element with req_ready low.
// one request at a time; the result waits in its register until taken.
`timescale 1ns / 1ps
module range_chmax_range_average
#(
    parameter int DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  rcra_pkg::req_t                 req,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rcra_pkg::res_t                 res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcra_pkg::IDX_W-1:0]     cfg_data
);
    import rcra_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW  = $clog2(DEPTH + 1);
    // largest length that the index fields can reach, capped at DEPTH
    localparam int CAP = (DEPTH < 2047) ? DEPTH : 2047;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_reg;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] len_reg;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [PW-1:0]    last_reg, last_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] flo_reg, flo_next;
    logic             act_reg, act_next;
    logic [NUM_W-1:0] sum_reg, sum_next;
    logic [NUM_W-1:0] ga_reg, ga_next;
    logic [NUM_W-1:0] gb_reg, gb_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             div_go_reg, div_go_next;
    res_t             res_reg, res_next;
    logic             wr_en;

    logic [NUM_W-1:0] div_a, div_b, div_q, div_r;
    div_ctl_t         dctl;

    logic [IDX_W:0] lim;
    logic           ok;

    rcra_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go_reg),
        .dividend  (div_a),
        .divisor   (div_b),
        .ctl       (dctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // range check against length capped at DEPTH
    always_comb
    begin
        if ({1'b0, len_reg} > (IDX_W+1)'(CAP))
            lim = (IDX_W+1)'(CAP);
        else
            lim = {1'b0, len_reg};
        ok = (req.first_index != '0) && (req.first_index <= req.last_index)
             && ({1'b0, req.last_index} <= lim);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (ptr_reg == PW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (req_valid)
                begin
                    if (ok)                     state_next = ST_READ;
                    else if (req.action == ACT_QUERY) state_next = ST_OUT;
                end
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_APPLY;
            ST_APPLY:
                if (ptr_reg == last_reg)
                    state_next = act_reg ? ST_GCD : ST_IDLE;
                else
                    state_next = ST_READ;
            ST_GCD:
                if (!div_go_reg && !dctl.busy && gb_reg == '0)
                    state_next = ST_DIV_N;
            ST_DIV_N:
                if (!div_go_reg && !dctl.busy) state_next = ST_DIV_D;
            ST_DIV_D:
                if (!div_go_reg && !dctl.busy) state_next = ST_OUT;
            ST_OUT:   if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        flo_next    = flo_reg;
        act_next    = act_reg;
        sum_next    = sum_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        num_next    = num_reg;
        div_go_next = 1'b0;
        res_next    = res_reg;
        wr_en       = 1'b0;
        div_a       = ga_reg;
        div_b       = gb_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            ST_IDLE:
                if (req_valid)
                begin
                    ptr_next  = PW'(req.first_index - 1'b1);
                    last_next = PW'(req.last_index - 1'b1);
                    cnt_next  = IDX_W'(req.last_index - req.first_index + 1'b1);
                    flo_next  = req.floor_value;
                    act_next  = req.action;
                    sum_next  = '0;
                    res_next  = '{numerator: '0, denominator: IDX_W'(1), range_error: 1'b1};
                end
            ST_APPLY:
            begin
                if (act_reg == ACT_RAISE)
                    wr_en = (rd_reg < flo_reg);
                else
                    sum_next = sum_reg + NUM_W'(rd_reg);
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == last_reg && act_reg == ACT_QUERY)
                begin
                    ga_next     = sum_next;
                    gb_next     = NUM_W'(cnt_reg);
                    div_go_next = (cnt_reg != '0);
                end
            end
            ST_GCD:
                if (!div_go_reg && !dctl.busy)
                begin
                    if (gb_reg == '0)
                    begin
                        // ga holds the gcd, never zero since count is nonzero
                        gb_next     = ga_reg;
                        div_go_next = 1'b1;
                    end
                    else
                    begin
                        ga_next     = gb_reg;
                        gb_next     = div_r;
                        div_go_next = (div_r != '0);
                    end
                end
            ST_DIV_N:
            begin
                // sum over gcd, then start the count over gcd
                div_a = sum_reg;
                if (!div_go_reg && !dctl.busy)
                begin
                    num_next    = div_q;
                    div_go_next = 1'b1;
                end
            end
            ST_DIV_D:
            begin
                div_a = NUM_W'(cnt_reg);
                if (!div_go_reg && !dctl.busy)
                    res_next = '{numerator: num_reg, denominator: div_q[IDX_W-1:0],
                                 range_error: 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            len_reg    <= IDX_W'(1024);
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            div_go_reg <= div_go_next;
            if (cfg_valid && cfg_ready)
                len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        cnt_reg  <= cnt_next;
        flo_reg  <= flo_next;
        act_reg  <= act_next;
        sum_reg  <= sum_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        num_reg  <= num_next;
        res_reg  <= res_next;
    end

    // element memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptr_reg[AW-1:0]] <= (state_reg == ST_CLEAR) ? '0 : flo_reg;
        rd_reg <= mem[ptr_reg[AW-1:0]];
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;
    assign cfg_ready = 1'b1;
endmodule

// File: hw/rtl/rcra_check.sv
// port checker for the range raise / range average block
// depends on rcra_pkg; bound to range_chmax_range_average
`timescale 1ns / 1ps
module rcra_check
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           res_valid,
    input logic           res_ready,
    input rcra_pkg::res_t res
);
    import rcra_pkg::*;

    // never ready for a request while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && res_valid)) else $error("ready with result pending");

    // result held until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped");

    // denominator never zero
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.denominator != '0) else $error("zero denominator");

    // an error result is 0/1
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.range_error |-> res.numerator == '0
        && res.denominator == IDX_W'(1)) else $error("bad error result");
endmodule

bind range_chmax_range_average rcra_check u_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
